/* rtl/rhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

	// histogram geometry
	localparam int LEVELS     = 256;
	localparam int LVL_W      = 8;
	localparam int CNT_W      = 13;
	localparam int MAX_WINDOW = 4096;
	localparam int FRAC_W     = 17;
	localparam int PROD_W     = CNT_W + FRAC_W;

	localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);
	localparam logic [PROD_W-1:0] FRAC_HALF  = PROD_W'(32768);

	// item kinds
	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_REM = 2'd1,
		KIND_QRY = 2'd2,
		KIND_CLR = 2'd3
	} kind_t;

	// control from the sequencer to one lane
	typedef struct packed {
		logic             rd;
		logic [LVL_W-1:0] addr;
		logic             wr;
		logic             inc;
		logic             clr;
		logic             scan_clr;
		logic             scan_acc;
	} lane_ctl_t;

	// status from one lane back to the sequencer
	typedef struct packed {
		logic             bin_zero;
		logic             found;
		logic [LVL_W-1:0] level;
	} lane_stat_t;

endpackage

`default_nettype wire

/* rtl/rhp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface rhp_in_if import rhp_pkg::*; ();
	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [LVL_W-1:0] red;
	logic [LVL_W-1:0] green;
	logic [LVL_W-1:0] blue;

	modport source (output valid, kind, red, green, blue, input ready);
	modport sink (input valid, kind, red, green, blue, output ready);
endinterface

// result channel
interface rhp_out_if import rhp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] out_red;
	logic [LVL_W-1:0] out_green;
	logic [LVL_W-1:0] out_blue;
	logic [CNT_W-1:0] total;
	logic             fault;

	modport source (output valid, out_red, out_green, out_blue, total, fault, input ready);
	modport sink (input valid, out_red, out_green, out_blue, total, fault, output ready);
endinterface

`default_nettype wire

/* rtl/rhp_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module rhp_lane import rhp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lane_ctl_t        ctl,
	input  wire logic [CNT_W-1:0] k,
	output lane_stat_t            stat
);

	logic [CNT_W-1:0] mem_q [LEVELS];
	logic [LEVELS-1:0] vld_q;
	logic [CNT_W-1:0] rd_data_q;
	logic             rd_vld_q;
	logic [LVL_W-1:0] rd_addr_q;
	logic [CNT_W-1:0] bin;
	logic [CNT_W-1:0] wr_data;
	logic [CNT_W:0]   run_q;
	logic [CNT_W:0]   run_sum;
	logic             found_q;
	logic [LVL_W-1:0] level_q;

	// bin of the last read, entries never written since clear read as zero
	assign bin     = rd_vld_q ? rd_data_q : '0;
	assign wr_data = ctl.inc ? bin + CNT_W'(1) : bin - CNT_W'(1);
	assign run_sum = run_q + {1'b0, bin};

	// bin memory, written back at the address just read
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem_q[ctl.addr];
			rd_addr_q <= ctl.addr;
		end
		if (ctl.wr) begin
			mem_q[rd_addr_q] <= wr_data;
		end
	end

	// per-entry valid bits, clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rd_vld_q <= vld_q[ctl.addr];
			end
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[rd_addr_q] <= 1'b1;
			end
		end
	end

	// running count over the scan, first level reaching k is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			found_q <= 1'b0;
			level_q <= '0;
		end else if (ctl.scan_clr) begin
			run_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.scan_acc) begin
			run_q <= run_sum;
			if (!found_q && run_sum >= {1'b0, k}) begin
				found_q <= 1'b1;
				level_q <= rd_addr_q;
			end
		end
	end

	assign stat.bin_zero = (bin == '0);
	assign stat.found    = found_q;
	assign stat.level    = found_q ? level_q : LVL_W'(LEVELS - 1);

endmodule

`default_nettype wire

/* rtl/rgb_histogram_percentile_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// add / remove / clear: result registered after the input transfer, held back while the output register is full
// clear: the clear itself takes effect at the transfer edge
// query: result registered after the multiply, the rounding of k and the 256-bin scan
// a new item is taken only once the previous one has reached the output register
// reset clears all bins (valid bits), the pixel total and sets the fraction to one half

module rgb_histogram_percentile_top import rhp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rhp_in_if.sink                 item,
	rhp_out_if.source              result,
	input  wire logic              cfg_we,
	input  wire logic [FRAC_W-1:0] cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHK   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_KCALC = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	kind_t             kind_q;
	logic [FRAC_W-1:0] fraction_q;
	logic [FRAC_W-1:0] frac_clamped;
	logic [CNT_W-1:0]  total_q;
	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W-1:0] prod_round;
	logic [CNT_W-1:0]  k_q;
	logic [LVL_W:0]    cnt_q;
	logic              scan_rd_s1;
	logic              accept;
	logic              emit_ok;
	logic              emit;
	logic              chk_fault;
	logic [CNT_W-1:0]  total_new;
	lane_ctl_t         ctl_base, ctl_r, ctl_g, ctl_b;
	lane_stat_t        stat_r, stat_g, stat_b;

	logic              out_valid_q;
	logic [LVL_W-1:0]  out_red_q, out_green_q, out_blue_q;
	logic [CNT_W-1:0]  out_total_q;
	logic              out_fault_q;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign emit_ok    = !out_valid_q || result.ready;

	// refused add / remove
	assign chk_fault = (kind_q == KIND_ADD) ? (total_q >= CNT_W'(MAX_WINDOW)) :
		(total_q == '0 || stat_r.bin_zero || stat_g.bin_zero || stat_b.bin_zero);
	assign total_new = chk_fault ? total_q :
		((kind_q == KIND_ADD) ? total_q + CNT_W'(1) : total_q - CNT_W'(1));

	// k = round(total * fraction / 2^16)
	assign frac_clamped = (fraction_q > FRAC_ONE) ? FRAC_ONE : fraction_q;
	assign prod_round   = prod_s1 + FRAC_HALF;

	// sequencer
	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		ctl_base = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.kind)
						KIND_ADD, KIND_REM: begin
							ctl_base.rd = 1'b1;
							state_d     = ST_CHK;
						end
						KIND_QRY: state_d = ST_MUL;
						KIND_CLR: begin
							ctl_base.clr = 1'b1;
							state_d      = ST_FIN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHK: begin
				if (emit_ok) begin
					emit         = 1'b1;
					ctl_base.wr  = !chk_fault;
					ctl_base.inc = (kind_q == KIND_ADD);
					state_d      = ST_IDLE;
				end
			end
			ST_MUL: state_d = ST_KCALC;
			ST_KCALC: begin
				ctl_base.scan_clr = 1'b1;
				state_d           = ST_SCAN;
			end
			ST_SCAN: begin
				ctl_base.rd       = !cnt_q[LVL_W];
				ctl_base.addr     = cnt_q[LVL_W-1:0];
				ctl_base.scan_acc = scan_rd_s1;
				if (cnt_q[LVL_W]) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// per-lane addresses on add / remove
	always_comb begin
		ctl_r = ctl_base;
		ctl_g = ctl_base;
		ctl_b = ctl_base;
		if (state_q == ST_IDLE) begin
			ctl_r.addr = item.red;
			ctl_g.addr = item.green;
			ctl_b.addr = item.blue;
		end
	end

	rhp_lane u_lane_r (.clk(clk), .arst_n(arst_n), .ctl(ctl_r), .k(k_q), .stat(stat_r));
	rhp_lane u_lane_g (.clk(clk), .arst_n(arst_n), .ctl(ctl_g), .k(k_q), .stat(stat_g));
	rhp_lane u_lane_b (.clk(clk), .arst_n(arst_n), .ctl(ctl_b), .k(k_q), .stat(stat_b));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= KIND_ADD;
			fraction_q <= FRAC_RESET;
			total_q    <= '0;
			cnt_q      <= '0;
			scan_rd_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			scan_rd_s1 <= (state_q == ST_SCAN) && !cnt_q[LVL_W];
			if (cfg_we) begin
				fraction_q <= cfg_wdata;
			end
			if (accept) begin
				kind_q <= item.kind;
				if (item.kind == KIND_CLR) begin
					total_q <= '0;
				end
			end
			if (state_q == ST_CHK && emit) begin
				total_q <= total_new;
			end
			if (state_q == ST_KCALC) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + (LVL_W+1)'(1);
			end
		end
	end

	// k arithmetic, multiply then round in the next cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1 <= PROD_W'(total_q) * PROD_W'(frac_clamped);
		end
		if (state_q == ST_KCALC) begin
			k_q <= prod_round[CNT_W+15:16];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (state_q == ST_FIN && kind_q == KIND_QRY) begin
				out_red_q   <= stat_r.level;
				out_green_q <= stat_g.level;
				out_blue_q  <= stat_b.level;
			end else begin
				out_red_q   <= '0;
				out_green_q <= '0;
				out_blue_q  <= '0;
			end
			out_total_q <= (state_q == ST_CHK) ? total_new : total_q;
			out_fault_q <= (state_q == ST_CHK) ? chk_fault : 1'b0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = out_red_q;
	assign result.out_green = out_green_q;
	assign result.out_blue  = out_blue_q;
	assign result.total     = out_total_q;
	assign result.fault     = out_fault_q;

	// window bound holds
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_WINDOW))
		else $error("pixel total above window bound");

	// a clear empties the histogram at once
	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_CLR) |=> (total_q == '0))
		else $error("clear did not zero the total");

	// k never exceeds the total, so every lane finds its level by the end of the scan
	a_scan_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && kind_q == KIND_QRY) |->
			(stat_r.found && stat_g.found && stat_b.found))
		else $error("scan ended without reaching k");

endmodule

`default_nettype wire
